>>> rtl/core/rtad_pkg.sv
// Shared widths, constants and the digit-to-ASCII map for the radix digit converter.
package rtad_pkg;

  // Field widths
  localparam int NUMBER_W = 31;
  localparam int RADIX_W  = 6;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 5;

  // Default digit limit per conversion
  localparam int MAX_DIGITS_DEF = 31;

  // Divider: quotient bits resolved per cycle
  localparam int DIV_STEPS = 4;

  // Legal radix range
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  // ASCII anchors
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A    = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] TEN       = 8'd10;

  // Remainder value to its ASCII digit: 0-9 then a-z
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] v);
    logic [CHAR_W-1:0] wide;
    wide = {{(CHAR_W-RADIX_W){1'b0}}, v};
    if (wide < TEN) begin
      return CHAR_ZERO + wide;
    end
    return CHAR_A + wide - TEN;
  endfunction

endpackage

>>> rtl/core/radix_to_ascii_digits_core.sv
// Top level of the radix digit converter: sequencer, digit store and output register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------
//   in      | input     | in_valid/in_stall  | number[30:0], radix[5:0]
//   out     | output    | out_valid/out_stall| digit_char[7:0], digit_count[4:0],
//           |           |                    | last, bad_radix
//
// Each digit costs one divider pass: a start strobe, the iterations of the shared divider
// (4 quotient bits per cycle over a 32-bit word) and a done strobe. Digits then leave
// one per cycle while out_stall is low, most significant first; the longest conversion
// is radix 2 with 31 digits. A zero input or a bad radix skips the divider. in_stall
// is high from the transfer until the last result's transfer.
// Synchronous reset clears the sequencer, the divider and out_valid; no clearing pass.
module radix_to_ascii_digits_core
  import rtad_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [NUMBER_W-1:0] number,
  input  logic [RADIX_W-1:0]  radix,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAR_W-1:0]   digit_char,
  output logic [COUNT_W-1:0]  digit_count,
  output logic                last,
  output logic                bad_radix
);

  // A 31-bit value never needs more than 31 digits
  localparam int DEPTH = (MAX_DIGITS < NUMBER_W) ? MAX_DIGITS : NUMBER_W;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SHOW
  } state_t;

  state_t              state;
  logic [NUMBER_W-1:0] value;
  logic [RADIX_W-1:0]  rdx;
  logic [COUNT_W-1:0]  n;
  logic [IDX_W-1:0]    rd;
  logic                div_start;
  logic                div_done;
  logic [NUMBER_W-1:0] div_quo;
  logic [RADIX_W-1:0]  div_rem;
  logic [COUNT_W-1:0]  n_next;

  // Digit store, least significant digit at index 0
  logic [RADIX_W-1:0]  digits [DEPTH];
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  logic [RADIX_W-1:0]  wr_data;

  rtad_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (value),
    .divisor   (rdx),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign in_stall = (state != ST_IDLE);
  assign n_next   = n + 1'b1;

  // Store write: remainder after each pass, or a lone zero digit
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = n[IDX_W-1:0];
    wr_data = div_rem;
    if (state == ST_IDLE && in_valid && number == '0) begin
      wr_en   = 1'b1;
      wr_idx  = '0;
      wr_data = '0;
    end else if (state == ST_DIV && div_done) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digits[wr_idx] <= wr_data;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            value <= number;
            rdx   <= radix;
            n     <= '0;
            if (radix < RADIX_MIN || radix > RADIX_MAX) begin
              out_valid   <= 1'b1;
              digit_char  <= '0;
              digit_count <= '0;
              last        <= 1'b1;
              bad_radix   <= 1'b1;
              rd          <= '0;
              state       <= ST_SHOW;
            end else if (number == '0) begin
              out_valid   <= 1'b1;
              digit_char  <= CHAR_ZERO;
              digit_count <= COUNT_W'(1);
              last        <= 1'b1;
              bad_radix   <= 1'b0;
              rd          <= '0;
              state       <= ST_SHOW;
            end else begin
              div_start <= 1'b1;
              state     <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            n     <= n_next;
            value <= div_quo;
            if (div_quo == '0 || n_next == COUNT_W'(DEPTH)) begin
              // Top digit is the remainder just produced
              out_valid   <= 1'b1;
              digit_char  <= digit_ascii(div_rem);
              digit_count <= n_next;
              last        <= (n == '0);
              bad_radix   <= 1'b0;
              rd          <= n[IDX_W-1:0];
              state       <= ST_SHOW;
            end else begin
              div_start <= 1'b1;
            end
          end
        end
        ST_SHOW: begin
          if (!out_stall) begin
            if (last) begin
              out_valid <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              digit_char <= digit_ascii(digits[rd - 1'b1]);
              last       <= (rd == IDX_W'(1));
              rd         <= rd - 1'b1;
            end
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/rtad_div.sv
// Iterative divider: 31-bit dividend by 6-bit divisor, several quotient bits per cycle.
module rtad_div
  import rtad_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUMBER_W-1:0] dividend,
  input  logic [RADIX_W-1:0]  divisor,
  output logic                done,
  output logic [NUMBER_W-1:0] quotient,
  output logic [RADIX_W-1:0]  remainder
);

  localparam int QW         = ((NUMBER_W + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
  localparam int DIV_CYCLES = QW / DIV_STEPS;
  localparam int CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [QW-1:0]       quo;
  logic [RADIX_W-1:0]  rem;
  logic [RADIX_W-1:0]  dvs;
  logic [QW-1:0]       quo_next;
  logic [RADIX_W-1:0]  rem_next;

  // Restoring division, DIV_STEPS shift-compare-subtract steps per cycle
  always_comb begin
    logic [RADIX_W:0] t;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t        = {rem_next, quo_next[QW-1]};
      quo_next = {quo_next[QW-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t           = t - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
      rem_next = t[RADIX_W-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= QW'(dividend);
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo[NUMBER_W-1:0];
  assign remainder = rem;

endmodule
